/* hdl/tcw_pkg.sv */
// Shared constants, types and codes for the text console writer.
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CUR_W  = $clog2(CELL_COUNT);
    localparam int IDX_W  = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam int DIV_K     = 20;
    localparam int DIV_RECIP = (1 << DIV_K) / COLUMNS;
    localparam int PROD_W    = IDX_W + DIV_K;
    localparam int MUL_W     = IDX_W + COL_W + 1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
    localparam logic [ATTR_W-1:0] BLANK_ATTR   = 8'h0f;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0f;

    typedef enum logic [1:0] {
        FUNC_WRITE     = 2'd0,
        FUNC_BACKSPACE = 2'd1,
        FUNC_CLEAR     = 2'd2,
        FUNC_READ      = 2'd3
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [CHAR_W-1:0] char_code;
        logic              in_range;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_op;

endpackage

/* hdl/tcw_front.sv */
// Request intake: latches a request and splits the read cell index into row and column.
module tcw_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_func,
    input  logic [7:0]                i_char_code,
    input  logic [10:0]               i_cell_index,
    output logic                      o_push,
    output tcw_pkg::t_op              o_push_op,
    input  logic                      i_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                        r_state, n_state;
    tcw_pkg::t_func                 r_func;
    logic [tcw_pkg::CHAR_W-1:0]     r_char;
    logic [tcw_pkg::IDX_W-1:0]      r_idx;
    logic [tcw_pkg::IDX_W-1:0]      r_qest;

    logic [tcw_pkg::PROD_W-1:0]     w_prod;
    logic [tcw_pkg::MUL_W-1:0]      w_mul;
    logic [tcw_pkg::MUL_W-1:0]      w_rem;
    logic                           w_fix;
    logic                           w_accept;

    assign w_accept   = i_in_valid && (r_state == F_IDLE);
    assign o_in_stall = (r_state != F_IDLE);

    assign w_prod = tcw_pkg::PROD_W'(r_idx) * tcw_pkg::PROD_W'(tcw_pkg::DIV_RECIP);
    assign w_mul  = tcw_pkg::MUL_W'(r_qest) * tcw_pkg::MUL_W'(tcw_pkg::COLUMNS);
    assign w_rem  = tcw_pkg::MUL_W'(r_idx) - w_mul;
    assign w_fix  = (w_rem >= tcw_pkg::MUL_W'(tcw_pkg::COLUMNS));

    always_comb begin
        o_push_op.func      = r_func;
        o_push_op.char_code = r_char;
        o_push_op.in_range  = (int'(r_idx) < tcw_pkg::CELL_COUNT);
        o_push_op.row       = tcw_pkg::ROW_W'(r_qest + tcw_pkg::IDX_W'(w_fix));
        o_push_op.col       = w_fix ? tcw_pkg::COL_W'(w_rem - tcw_pkg::MUL_W'(tcw_pkg::COLUMNS))
                                    : tcw_pkg::COL_W'(w_rem);
    end

    assign o_push = (r_state == F_PUSH) && !i_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) n_state = F_MUL;
            end
            F_MUL: begin
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= tcw_pkg::t_func'(i_func);
            r_char <= i_char_code;
            r_idx  <= i_cell_index;
        end
        if (r_state == F_MUL) begin
            r_qest <= w_prod[tcw_pkg::DIV_K +: tcw_pkg::IDX_W];
        end
    end

endmodule

/* hdl/tcw_queue.sv */
// Two-entry request queue between intake and execution.
module tcw_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  tcw_pkg::t_op i_push_op,
    output logic         o_full,
    input  logic         i_pop,
    output tcw_pkg::t_op o_pop_op,
    output logic         o_empty
);

    tcw_pkg::t_op r_entry [0:1];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;

    assign o_full   = (r_count == 2'd2);
    assign o_empty  = (r_count == 2'd0);
    assign o_pop_op = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_entry[r_wr_ptr] <= i_push_op;
    end

endmodule

/* hdl/tcw_back.sv */
// Execution: cursor, row rotation, screen memory, row fill and result register.
module tcw_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [7:0]                 i_cfg_data,
    input  logic                       i_empty,
    input  tcw_pkg::t_op               i_op,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [10:0]                o_cursor_cell,
    output logic [7:0]                 o_read_char,
    output logic [7:0]                 o_read_attr
);

    localparam int ROW_W = tcw_pkg::ROW_W;
    localparam int COL_W = tcw_pkg::COL_W;
    localparam int CUR_W = tcw_pkg::CUR_W;
    localparam int AW    = ROW_W + COL_W;
    localparam int DEPTH = 1 << AW;

    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(tcw_pkg::COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(tcw_pkg::ROWS - 1);
    localparam logic [CUR_W-1:0] LAST_BASE = CUR_W'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS);
    localparam logic [CUR_W-1:0] COLS_CUR  = CUR_W'(tcw_pkg::COLUMNS);

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_PREP  = 6'b000010,
        B_FILL  = 6'b000100,
        B_WRITE = 6'b001000,
        B_READ  = 6'b010000,
        B_DONE  = 6'b100000
    } t_bstate;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (ROW_W+1)'(tcw_pkg::ROWS)) sum = sum - (ROW_W+1)'(tcw_pkg::ROWS);
        return sum[ROW_W-1:0];
    endfunction

    t_bstate                      r_state, n_state;
    logic [ROW_W-1:0]             r_cur_row, n_cur_row;
    logic [COL_W-1:0]             r_cur_col, n_cur_col;
    logic [CUR_W-1:0]             r_cursor, n_cursor;
    logic [ROW_W-1:0]             r_top, n_top;
    logic [tcw_pkg::ROWS-1:0]     r_row_valid, n_row_valid;
    logic [7:0]                   r_attr;
    logic                         r_out_valid, n_out_valid;

    tcw_pkg::t_op                 r_op;
    logic [ROW_W-1:0]             r_tgt_phys, n_tgt_phys;
    logic [COL_W-1:0]             r_tgt_col, n_tgt_col;
    logic [tcw_pkg::CELL_W-1:0]   r_tgt_data, n_tgt_data;
    logic [COL_W-1:0]             r_fill_cnt, n_fill_cnt;
    logic [7:0]                   r_rc, n_rc;
    logic [7:0]                   r_ra, n_ra;
    logic [10:0]                  r_out_cursor;
    logic [7:0]                   r_out_char;
    logic [7:0]                   r_out_attr;

    logic [tcw_pkg::CELL_W-1:0]   r_mem [0:DEPTH-1];
    logic [tcw_pkg::CELL_W-1:0]   r_mem_rdata;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [tcw_pkg::CELL_W-1:0]   w_wdata;
    logic [AW-1:0]                w_raddr;

    logic [ROW_W-1:0]             w_cur_phys;
    logic [ROW_W-1:0]             w_rd_phys;
    logic [ROW_W-1:0]             w_prev_row;
    logic [COL_W-1:0]             w_prev_col;
    logic [ROW_W-1:0]             w_prev_phys;
    logic [ROW_W-1:0]             w_top_inc;
    logic                         w_out_free;
    logic                         w_load_out;

    assign w_cur_phys  = phys_row(r_cur_row, r_top);
    assign w_rd_phys   = phys_row(r_op.row, r_top);
    assign w_prev_col  = (r_cur_col == '0) ? LAST_COL : r_cur_col - COL_W'(1);
    assign w_prev_row  = (r_cur_col == '0) ? r_cur_row - ROW_W'(1) : r_cur_row;
    assign w_prev_phys = phys_row(w_prev_row, r_top);
    assign w_top_inc   = (r_top == LAST_ROW) ? '0 : r_top + ROW_W'(1);
    assign w_raddr     = {w_rd_phys, r_op.col};
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load_out  = (r_state == B_DONE) && w_out_free;
    assign o_pop       = (r_state == B_IDLE) && !i_empty;

    always_comb begin
        n_state     = r_state;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_cursor    = r_cursor;
        n_top       = r_top;
        n_row_valid = r_row_valid;
        n_tgt_phys  = r_tgt_phys;
        n_tgt_col   = r_tgt_col;
        n_tgt_data  = r_tgt_data;
        n_fill_cnt  = r_fill_cnt;
        n_rc        = r_rc;
        n_ra        = r_ra;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_waddr     = {r_tgt_phys, r_tgt_col};
        w_wdata     = r_tgt_data;

        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) n_state = B_PREP;
            end
            B_PREP: begin
                n_rc       = '0;
                n_ra       = '0;
                n_fill_cnt = '0;
                n_state    = B_DONE;
                case (r_op.func)
                    tcw_pkg::FUNC_CLEAR: begin
                        n_row_valid = '0;
                        n_top       = '0;
                        n_cur_row   = '0;
                        n_cur_col   = '0;
                        n_cursor    = '0;
                    end
                    tcw_pkg::FUNC_READ: begin
                        if (r_op.in_range) n_state = B_READ;
                    end
                    tcw_pkg::FUNC_BACKSPACE: begin
                        if (r_cursor != '0) begin
                            n_cur_row  = w_prev_row;
                            n_cur_col  = w_prev_col;
                            n_cursor   = r_cursor - CUR_W'(1);
                            n_tgt_phys = w_prev_phys;
                            n_tgt_col  = w_prev_col;
                            n_tgt_data = {tcw_pkg::BLANK_ATTR, 8'h00};
                            n_state    = r_row_valid[w_prev_phys] ? B_WRITE : B_FILL;
                        end
                    end
                    default: begin
                        if (r_op.char_code == tcw_pkg::NEWLINE_CODE) begin
                            n_cur_col = '0;
                            if (r_cur_row == LAST_ROW) begin
                                n_cursor           = LAST_BASE;
                                n_top              = w_top_inc;
                                n_row_valid[r_top] = 1'b0;
                            end else begin
                                n_cur_row = r_cur_row + ROW_W'(1);
                                n_cursor  = r_cursor - CUR_W'(r_cur_col) + COLS_CUR;
                            end
                        end else begin
                            n_tgt_phys = w_cur_phys;
                            n_tgt_col  = r_cur_col;
                            n_tgt_data = {r_attr, r_op.char_code};
                            n_state    = r_row_valid[w_cur_phys] ? B_WRITE : B_FILL;
                            if (r_cur_col == LAST_COL) begin
                                n_cur_col = '0;
                                if (r_cur_row == LAST_ROW) begin
                                    n_cursor           = LAST_BASE;
                                    n_top              = w_top_inc;
                                    n_row_valid[r_top] = 1'b0;
                                end else begin
                                    n_cur_row = r_cur_row + ROW_W'(1);
                                    n_cursor  = r_cursor + CUR_W'(1);
                                end
                            end else begin
                                n_cur_col = r_cur_col + COL_W'(1);
                                n_cursor  = r_cursor + CUR_W'(1);
                            end
                        end
                    end
                endcase
            end
            B_FILL: begin
                w_we       = 1'b1;
                w_waddr    = {r_tgt_phys, r_fill_cnt};
                w_wdata    = (r_fill_cnt == r_tgt_col) ? r_tgt_data : '0;
                n_fill_cnt = r_fill_cnt + COL_W'(1);
                if (r_fill_cnt == LAST_COL) begin
                    n_row_valid[r_tgt_phys] = 1'b1;
                    n_state                 = B_DONE;
                end
            end
            B_WRITE: begin
                w_we    = 1'b1;
                n_state = B_DONE;
            end
            B_READ: begin
                if (r_row_valid[w_rd_phys]) begin
                    n_rc = r_mem_rdata[7:0];
                    n_ra = r_mem_rdata[15:8];
                end
                n_state = B_DONE;
            end
            B_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_cursor    <= '0;
            r_top       <= '0;
            r_row_valid <= '0;
            r_attr      <= tcw_pkg::ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_cursor    <= n_cursor;
            r_top       <= n_top;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) r_attr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_op <= i_op;
        r_tgt_phys <= n_tgt_phys;
        r_tgt_col  <= n_tgt_col;
        r_tgt_data <= n_tgt_data;
        r_fill_cnt <= n_fill_cnt;
        r_rc       <= n_rc;
        r_ra       <= n_ra;
        if (w_load_out) begin
            r_out_cursor <= 11'(r_cursor);
            r_out_char   <= r_rc;
            r_out_attr   <= r_ra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_mem_rdata <= r_mem[w_raddr];
    end

    assign o_out_valid   = r_out_valid;
    assign o_cursor_cell = r_out_cursor;
    assign o_read_char   = r_out_char;
    assign o_read_attr   = r_out_attr;

endmodule

/* hdl/text_console_writer.sv */
// Top level of the text console writer: intake, request queue and execution.
//
// Input channel: i_in_valid / o_in_stall with i_func, i_char_code, i_cell_index.
// A request is taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall with o_cursor_cell, o_read_char,
// o_read_attr; one result per request, in request order, held while stalled.
// Configuration: i_cfg_valid / o_cfg_ready / i_cfg_data write the attribute
// byte; o_cfg_ready is always high. Write only while no request is in flight.
// Intake splits the index by reciprocal multiply and takes no new request
// until it has pushed the last one into the queue. Execution prepares each
// request, then writes or reads the screen memory, then registers the result,
// and takes the next one only after that; clear, newline and the no-op cases
// (backspace at cell zero, read out of range) skip the memory step.
// A character or backspace landing in a row that is blank after reset, clear
// or scroll first sweeps that row of the screen memory, one cell per cycle.
// Scroll itself is a row rotation and writes no screen memory.
// A two-entry queue lets intake keep taking requests while execution or the
// receiver stalls, until the queue is full. Synchronous active-low reset blanks
// the screen, homes the cursor and sets the attribute to 0x0f.
module text_console_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_cursor_cell,
    output logic [7:0]  o_read_char,
    output logic [7:0]  o_read_attr,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic         w_push;
    tcw_pkg::t_op w_push_op;
    logic         w_full;
    logic         w_pop;
    tcw_pkg::t_op w_pop_op;
    logic         w_empty;

    assign o_cfg_ready = 1'b1;

    tcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_push       (w_push),
        .o_push_op    (w_push_op),
        .i_full       (w_full)
    );

    tcw_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_op (w_push_op),
        .o_full    (w_full),
        .i_pop     (w_pop),
        .o_pop_op  (w_pop_op),
        .o_empty   (w_empty)
    );

    tcw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_empty       (w_empty),
        .i_op          (w_pop_op),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cursor_cell (o_cursor_cell),
        .o_read_char   (o_read_char),
        .o_read_attr   (o_read_attr)
    );

endmodule
